// ===== sv/iorf_pkg.sv =====
// Package for the I/O register file with byte DMA.
// Holds command and result-kind codes, port addresses, the store access struct
// and the port read mask function. No dependencies.
package iorf_pkg;

    // Input commands (2 bits; the fourth code means nothing and is dropped)
    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_DATA  = 2'd2;

    // Result kinds
    typedef enum logic [2:0] {
        KIND_RDATA = 3'd0,
        KIND_MRD   = 3'd1,
        KIND_MWR   = 3'd2,
        KIND_ARD   = 3'd3,
        KIND_AWR   = 3'd4
    } t_kind;

    // Ports with special behavior
    localparam logic [7:0] PORT_SRC_LO  = 8'h40;
    localparam logic [7:0] PORT_SRC_MID = 8'h41;
    localparam logic [7:0] PORT_DST_LO  = 8'h44;
    localparam logic [7:0] PORT_DST_MID = 8'h45;
    localparam logic [7:0] PORT_CNT_LO  = 8'h46;
    localparam logic [7:0] PORT_CNT_HI  = 8'h47;
    localparam logic [7:0] PORT_DMA_CTL = 8'h48;
    localparam logic [7:0] PORT_AUD_W   = 8'h52;
    localparam logic [7:0] PORT_AUD_LO  = 8'h80;
    localparam logic [7:0] PORT_AUD_HI  = 8'h94;
    localparam logic [7:0] PORT_INT_ACK = 8'hB6;
    localparam logic [7:0] DMA_START_BIT = 8'h80;

    // Store access request from the controller
    typedef struct packed {
        logic       we;
        logic [7:0] waddr;
        logic [7:0] wdata;
        logic       re;
        logic [7:0] raddr;
    } t_mem_req;

    function automatic logic is_audio_read(input logic [7:0] p);
        return (p inside {[PORT_AUD_LO:PORT_AUD_HI]});
    endfunction

    function automatic logic is_audio_write(input logic [7:0] p);
        return (p == PORT_AUD_W) || (p inside {[PORT_AUD_LO:PORT_AUD_HI]});
    endfunction

    // Fixed per-port read masks and constants
    function automatic logic [7:0] read_mask(input logic [7:0] p, input logic [7:0] s);
        logic [7:0] r;
        case (p)
            8'hAA:                                     r = 8'hFF;
            8'hB3, 8'hBA, 8'hBB, 8'hC4, 8'hC5, 8'hCB: r = 8'h00;
            8'hBE, 8'hC8:                              r = s | 8'h03;
            8'hC0:                                     r = (s & 8'h0F) | 8'h20;
            8'hCA:                                     r = s | 8'h80;
            default:                                   r = s;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/iorf_store.sv =====
// 256 x 8 register store: one write port, one read port, registered read data.
// Entries read as zero until first written after reset. Uses iorf_pkg.
module iorf_store (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  iorf_pkg::t_mem_req i_req,
    output logic [7:0]         o_rdata
);

    logic [7:0] mem [256];
    logic [255:0] r_valid;
    logic [7:0] r_rdata;
    logic       r_rvalid;

    // Per-entry written flags, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.we) begin
            r_valid[i_req.waddr] <= 1'b1;
        end
    end

    // Storage array
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // Registered read; data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata  <= mem[i_req.raddr];
            r_rvalid <= r_valid[i_req.raddr];
        end
    end

    assign o_rdata = r_rvalid ? r_rdata : 8'h00;

endmodule

// ===== sv/iorf_ctrl.sv =====
// Controller: port command decode, DMA sequencer and output register.
// Drives the register store through iorf_pkg::t_mem_req. Uses iorf_pkg.
module iorf_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input items
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_command,
    input  logic [7:0]         i_port,
    input  logic [7:0]         i_value,
    // result items
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [2:0]         o_kind,
    output logic [19:0]        o_address,
    output logic [7:0]         o_data,
    output logic               o_last,
    // store
    output iorf_pkg::t_mem_req o_mem,
    input  logic [7:0]         i_rdata
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_RD    = 7'b0000010,
        ST_B6    = 7'b0000100,
        ST_LOAD  = 7'b0001000,
        ST_START = 7'b0010000,
        ST_REQ   = 7'b0100000,
        ST_FIN   = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic [3:0]  r_step, n_step;
    logic [7:0]  r_port, n_port;
    logic [7:0]  r_value, n_value;
    logic        r_busy, n_busy;
    logic [19:0] r_src, n_src;
    logic [19:0] r_dst, n_dst;
    logic [15:0] r_rem, n_rem;

    logic        r_out_valid, n_out_valid;
    logic [2:0]  r_kind, n_kind;
    logic [19:0] r_addr, n_addr;
    logic [7:0]  r_data, n_data;
    logic        r_last, n_last;

    logic out_free;
    logic accept;
    logic [2:0] cap_idx;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE) && out_free;
    assign accept     = i_in_valid && o_in_ready;
    assign cap_idx    = 3'(r_step - 4'd1);

    // Next-state logic
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_port      = r_port;
        n_value     = r_value;
        n_busy      = r_busy;
        n_src       = r_src;
        n_dst       = r_dst;
        n_rem       = r_rem;
        n_out_valid = r_out_valid && !i_out_ready;
        n_kind      = r_kind;
        n_addr      = r_addr;
        n_data      = r_data;
        n_last      = r_last;
        o_mem       = '0;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_port  = i_port;
                    n_value = i_value;
                    case (i_command)
                        iorf_pkg::CMD_DATA: begin
                            if (r_busy) begin
                                // forward returned byte to destination
                                n_out_valid = 1'b1;
                                n_kind = iorf_pkg::KIND_MWR;
                                n_addr = r_dst;
                                n_data = i_value;
                                n_last = (r_rem == 16'd1);
                                n_src  = r_src + 20'd1;
                                n_dst  = r_dst + 20'd1;
                                n_rem  = r_rem - 16'd1;
                                n_step = '0;
                                n_state = (r_rem == 16'd1) ? ST_FIN : ST_REQ;
                            end
                        end
                        iorf_pkg::CMD_READ: begin
                            if (!r_busy) begin
                                if (iorf_pkg::is_audio_read(i_port)) begin
                                    n_out_valid = 1'b1;
                                    n_kind = iorf_pkg::KIND_ARD;
                                    n_addr = {12'd0, i_port};
                                    n_data = 8'h00;
                                    n_last = 1'b1;
                                end else begin
                                    o_mem.re    = 1'b1;
                                    o_mem.raddr = i_port;
                                    n_state     = ST_RD;
                                end
                            end
                        end
                        iorf_pkg::CMD_WRITE: begin
                            if (!r_busy) begin
                                if (iorf_pkg::is_audio_write(i_port)) begin
                                    n_out_valid = 1'b1;
                                    n_kind = iorf_pkg::KIND_AWR;
                                    n_addr = {12'd0, i_port};
                                    n_data = i_value;
                                    n_last = 1'b1;
                                end else if (i_port == iorf_pkg::PORT_INT_ACK) begin
                                    o_mem.re    = 1'b1;
                                    o_mem.raddr = i_port;
                                    n_state     = ST_B6;
                                end else if (i_port == iorf_pkg::PORT_DMA_CTL &&
                                             (i_value & iorf_pkg::DMA_START_BIT) != 8'h00) begin
                                    n_step  = '0;
                                    n_state = ST_LOAD;
                                end else begin
                                    o_mem.we    = 1'b1;
                                    o_mem.waddr = i_port;
                                    o_mem.wdata = i_value;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end

            // masked port read data
            ST_RD: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_kind  = iorf_pkg::KIND_RDATA;
                    n_addr  = '0;
                    n_data  = iorf_pkg::read_mask(r_port, i_rdata);
                    n_last  = 1'b1;
                    n_state = ST_IDLE;
                end
            end

            // interrupt acknowledge: clear bits written as 1
            ST_B6: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = iorf_pkg::PORT_INT_ACK;
                o_mem.wdata = i_rdata & ~r_value;
                n_state     = ST_IDLE;
            end

            // read 0x40..0x47, capturing each byte in the step after its read
            ST_LOAD: begin
                if (r_step != 4'd8) begin
                    o_mem.re    = 1'b1;
                    o_mem.raddr = iorf_pkg::PORT_SRC_LO + {5'd0, r_step[2:0]};
                end
                if (r_step != 4'd0) begin
                    case (cap_idx)
                        3'd0:    n_src[7:0]   = i_rdata;
                        3'd1:    n_src[15:8]  = i_rdata;
                        3'd2:    n_src[19:16] = i_rdata[3:0];
                        3'd3:    n_dst[19:16] = i_rdata[3:0];
                        3'd4:    n_dst[7:0]   = i_rdata;
                        3'd5:    n_dst[15:8]  = i_rdata;
                        3'd6:    n_rem[7:0]   = i_rdata;
                        default: n_rem[15:8]  = i_rdata;
                    endcase
                end
                n_step = r_step + 4'd1;
                if (r_step == 4'd8) begin
                    n_state = ST_START;
                end
            end

            // zero count ends at once; otherwise first read request
            ST_START: begin
                if (r_rem == 16'd0) begin
                    o_mem.we    = 1'b1;
                    o_mem.waddr = iorf_pkg::PORT_DMA_CTL;
                    o_mem.wdata = 8'h00;
                    n_state     = ST_IDLE;
                end else if (out_free) begin
                    o_mem.we    = 1'b1;
                    o_mem.waddr = iorf_pkg::PORT_DMA_CTL;
                    o_mem.wdata = r_value;
                    n_busy      = 1'b1;
                    n_out_valid = 1'b1;
                    n_kind  = iorf_pkg::KIND_MRD;
                    n_addr  = r_src;
                    n_data  = 8'h00;
                    n_last  = 1'b1;
                    n_state = ST_IDLE;
                end
            end

            // next read request after a memory write
            ST_REQ: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_kind  = iorf_pkg::KIND_MRD;
                    n_addr  = r_src;
                    n_data  = 8'h00;
                    n_last  = 1'b1;
                    n_state = ST_IDLE;
                end
            end

            // write back count, addresses and control, one entry a cycle
            ST_FIN: begin
                o_mem.we = 1'b1;
                case (r_step[2:0])
                    3'd0: begin
                        o_mem.waddr = iorf_pkg::PORT_CNT_LO;
                        o_mem.wdata = 8'h00;
                    end
                    3'd1: begin
                        o_mem.waddr = iorf_pkg::PORT_CNT_HI;
                        o_mem.wdata = 8'h00;
                    end
                    3'd2: begin
                        o_mem.waddr = iorf_pkg::PORT_SRC_LO;
                        o_mem.wdata = r_src[7:0];
                    end
                    3'd3: begin
                        o_mem.waddr = iorf_pkg::PORT_SRC_MID;
                        o_mem.wdata = r_src[15:8];
                    end
                    3'd4: begin
                        o_mem.waddr = iorf_pkg::PORT_DST_LO;
                        o_mem.wdata = r_dst[7:0];
                    end
                    3'd5: begin
                        o_mem.waddr = iorf_pkg::PORT_DST_MID;
                        o_mem.wdata = r_dst[15:8];
                    end
                    default: begin
                        o_mem.waddr = iorf_pkg::PORT_DMA_CTL;
                        o_mem.wdata = 8'h00;
                    end
                endcase
                n_step = r_step + 4'd1;
                if (r_step == 4'd6) begin
                    n_busy  = 1'b0;
                    n_rem   = '0;
                    n_state = ST_IDLE;
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_busy      <= 1'b0;
            r_src       <= '0;
            r_dst       <= '0;
            r_rem       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_busy      <= n_busy;
            r_src       <= n_src;
            r_dst       <= n_dst;
            r_rem       <= n_rem;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_port  <= n_port;
        r_value <= n_value;
        r_kind  <= n_kind;
        r_addr  <= n_addr;
        r_data  <= n_data;
        r_last  <= n_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_address   = r_addr;
    assign o_data      = r_data;
    assign o_last      = r_last;

endmodule

// ===== sv/io_register_file_with_dma.sv =====
// I/O register file with byte DMA: a 256 x 8 store on an 8-bit port bus, kept in
// one synchronous memory and accessed one item at a time. Port writes and audio
// forwards finish when the item is accepted; port reads and interrupt-acknowledge
// writes (0xB6) also wait for the registered memory read; DMA data bytes that leave
// bytes to copy do the memory write, then the next read request; a DMA start does
// eight store reads of 0x40..0x47, captures the last one and takes one start step,
// and the last DMA byte does seven write-backs through the single store write port.
// Output stalls add cycles. Store entries read as zero after reset. Port accesses
// during a DMA are dropped without result.
// Depends on iorf_pkg, iorf_ctrl and iorf_store.
module io_register_file_with_dma (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] port, [15:8] value
    input  logic [1:0]  s_axis_tuser,   // [1:0] command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [19:0] address, [27:20] data, [31:28] zero
    output logic [2:0]  m_axis_tuser,   // [2:0] kind
    output logic        m_axis_tlast    // last result of an input item
);

    iorf_pkg::t_mem_req mem_req;
    logic [7:0]  rdata;
    logic [19:0] out_addr;
    logic [7:0]  out_data;

    iorf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_command   (s_axis_tuser),
        .i_port      (s_axis_tdata[7:0]),
        .i_value     (s_axis_tdata[15:8]),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_kind      (m_axis_tuser),
        .o_address   (out_addr),
        .o_data      (out_data),
        .o_last      (m_axis_tlast),
        .o_mem       (mem_req),
        .i_rdata     (rdata)
    );

    iorf_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_rdata (rdata)
    );

    assign m_axis_tdata = {4'd0, out_data, out_addr};

endmodule

// ===== dv/iorf_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the I/O register file with byte DMA: mirrors the register store and
// the DMA state from accepted input items and checks every result item in order.
// Depends on iorf_pkg.
module iorf_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] port, [15:8] value
    input  logic [1:0]  s_axis_tuser,   // [1:0] command
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,   // [19:0] address, [27:20] data, [31:28] zero
    input  logic [2:0]  m_axis_tuser,   // [2:0] kind
    input  logic        m_axis_tlast,
    output int          o_fail_count,
    output int          o_pending
);

    // DMA address high bytes
    localparam logic [7:0] PORT_SRC_HI = 8'h42;
    localparam logic [7:0] PORT_DST_HI = 8'h43;

    // Ports with fixed read behavior
    localparam logic [7:0]  PORT_READ_ONES = 8'hAA;
    localparam logic [7:0]  PORT_LOW_NIB   = 8'hC0;
    localparam logic [7:0]  PORT_TOP_BIT   = 8'hCA;
    localparam logic [47:0] ZERO_PORTS     = {8'hB3, 8'hBA, 8'hBB, 8'hC4, 8'hC5, 8'hCB};
    localparam logic [15:0] LOW2_PORTS     = {8'hBE, 8'hC8};

    typedef struct packed {
        iorf_pkg::t_kind kind;
        logic [19:0]     address;
        logic [7:0]      data;
        logic            last;
    } t_bus_result;

    t_bus_result results_due[$];
    t_bus_result head;

    logic [7:0]  regs [256];
    logic        dma_active;
    logic [15:0] bytes_left;
    logic [19:0] src_addr;
    logic [19:0] dst_addr;

    function automatic void queue_result(iorf_pkg::t_kind kind, logic [19:0] addr,
                                         logic [7:0] data, logic last);
        t_bus_result r;
        r.kind    = kind;
        r.address = addr;
        r.data    = data;
        r.last    = last;
        results_due.push_back(r);
    endfunction

    // Value seen on a port read, after the fixed per-port masks
    function automatic logic [7:0] port_read_value(logic [7:0] port);
        logic [7:0] val;
        val = regs[port];
        if (port == PORT_READ_ONES) val = 8'hFF;
        if (port == PORT_LOW_NIB)   val = (regs[port] & 8'h0F) | 8'h20;
        if (port == PORT_TOP_BIT)   val = regs[port] | 8'h80;
        for (int i = 0; i < 2; i++)
            if (port == LOW2_PORTS[i*8 +: 8]) val = regs[port] | 8'h03;
        for (int i = 0; i < 6; i++)
            if (port == ZERO_PORTS[i*8 +: 8]) val = 8'h00;
        return val;
    endfunction

    // End of a DMA: clear the count, write back the low address bytes, drop the start bit
    function automatic void close_dma();
        regs[iorf_pkg::PORT_CNT_LO]   = 8'h00;
        regs[iorf_pkg::PORT_CNT_HI]   = 8'h00;
        regs[iorf_pkg::PORT_SRC_LO]   = src_addr[7:0];
        regs[iorf_pkg::PORT_SRC_MID]  = src_addr[15:8];
        regs[iorf_pkg::PORT_DST_LO]   = dst_addr[7:0];
        regs[iorf_pkg::PORT_DST_MID]  = dst_addr[15:8];
        regs[iorf_pkg::PORT_DMA_CTL]  = 8'h00;
        dma_active                    = 1'b0;
        bytes_left                    = 16'd0;
    endfunction

    function automatic void apply_bus_item(logic [1:0] cmd, logic [7:0] port, logic [7:0] val);
        logic last_byte;
        if (cmd == iorf_pkg::CMD_DATA) begin
            if (dma_active) begin
                last_byte = (bytes_left == 16'd1);
                queue_result(iorf_pkg::KIND_MWR, dst_addr, val, last_byte);
                src_addr   = src_addr + 20'd1;
                dst_addr   = dst_addr + 20'd1;
                bytes_left = bytes_left - 16'd1;
                if (last_byte)
                    close_dma();
                else
                    queue_result(iorf_pkg::KIND_MRD, src_addr, 8'h00, 1'b1);
            end
        end else if (cmd == iorf_pkg::CMD_READ && !dma_active) begin
            if (port >= iorf_pkg::PORT_AUD_LO && port <= iorf_pkg::PORT_AUD_HI)
                queue_result(iorf_pkg::KIND_ARD, {12'd0, port}, 8'h00, 1'b1);
            else
                queue_result(iorf_pkg::KIND_RDATA, 20'd0, port_read_value(port), 1'b1);
        end else if (cmd == iorf_pkg::CMD_WRITE && !dma_active) begin
            if (port == iorf_pkg::PORT_AUD_W ||
                (port >= iorf_pkg::PORT_AUD_LO && port <= iorf_pkg::PORT_AUD_HI)) begin
                queue_result(iorf_pkg::KIND_AWR, {12'd0, port}, val, 1'b1);
            end else if (port == iorf_pkg::PORT_INT_ACK) begin
                regs[port] = regs[port] & ~val;
            end else if (port == iorf_pkg::PORT_DMA_CTL &&
                         (val & iorf_pkg::DMA_START_BIT) != 8'h00) begin
                src_addr   = {regs[PORT_SRC_HI][3:0], regs[iorf_pkg::PORT_SRC_MID],
                              regs[iorf_pkg::PORT_SRC_LO]};
                dst_addr   = {regs[PORT_DST_HI][3:0], regs[iorf_pkg::PORT_DST_MID],
                              regs[iorf_pkg::PORT_DST_LO]};
                bytes_left = {regs[iorf_pkg::PORT_CNT_HI], regs[iorf_pkg::PORT_CNT_LO]};
                if (bytes_left == 16'd0) begin
                    close_dma();
                end else begin
                    dma_active                   = 1'b1;
                    regs[iorf_pkg::PORT_DMA_CTL] = val;
                    queue_result(iorf_pkg::KIND_MRD, src_addr, 8'h00, 1'b1);
                end
            end else begin
                regs[port] = val;
            end
        end
    endfunction

    // Inputs are predicted before outputs are checked, so same-edge results are safe
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            results_due.delete();
            foreach (regs[i]) regs[i] = 8'h00;
            dma_active   = 1'b0;
            bytes_left   = 16'd0;
            src_addr     = 20'd0;
            dst_addr     = 20'd0;
            o_fail_count = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                apply_bus_item(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[15:8]);
            if (m_axis_tvalid && m_axis_tready) begin
                if (results_due.size() == 0) begin
                    $error("result item with none due: kind %0d address 0x%05h data 0x%02h",
                           m_axis_tuser, m_axis_tdata[19:0], m_axis_tdata[27:20]);
                    o_fail_count++;
                end else begin
                    head = results_due.pop_front();
                    if (m_axis_tuser !== head.kind) begin
                        $error("kind: expected %0d, got %0d", head.kind, m_axis_tuser);
                        o_fail_count++;
                    end
                    if (m_axis_tdata[19:0] !== head.address) begin
                        $error("address: expected 0x%05h, got 0x%05h",
                               head.address, m_axis_tdata[19:0]);
                        o_fail_count++;
                    end
                    if (m_axis_tdata[27:20] !== head.data) begin
                        $error("data: expected 0x%02h, got 0x%02h",
                               head.data, m_axis_tdata[27:20]);
                        o_fail_count++;
                    end
                    if (m_axis_tlast !== head.last) begin
                        $error("last: expected %0d, got %0d", head.last, m_axis_tlast);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = results_due.size();
    end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the I/O register file with byte DMA: clock, reset, port and DMA
// stimulus, result back-pressure, watchdog and verdict.
// Depends on iorf_pkg, io_register_file_with_dma and iorf_checker.
module tb;

    localparam int         QUIET_LIMIT = 1000;
    localparam int         ITEM_TARGET = 800;
    localparam logic [1:0] CMD_NONE    = 2'd3;   // undefined command, dropped by the block

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // [7:0] port, [15:8] value
    logic [1:0]  s_axis_tuser;   // [1:0] command
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // [19:0] address, [27:20] data, [31:28] zero
    logic [2:0]  m_axis_tuser;   // [2:0] kind
    logic        m_axis_tlast;

    int   fail_count;
    int   pending;
    int   items_sent;
    int   quiet_cycles = 0;
    logic no_idle;

    io_register_file_with_dma u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    iorf_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Watchdog: ends the run when nothing moves on either side for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("[io_register_file_with_dma] ERROR");
            $finish;
        end
    end

    // Result side: random stall before each result item, none while no_idle is set
    initial begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 3);
            repeat (stall) begin
                @(negedge i_clk);
                m_axis_tready <= 1'b0;
            end
            @(negedge i_clk);
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    // One input item after a random gap; returns at the accepting edge
    task automatic send_item(input logic [1:0] cmd, input logic [7:0] port,
                             input logic [7:0] val);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        repeat (gap) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {val, port};
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
    endtask

    // Hold the input side until every result due has arrived
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // Any item while a DMA runs: port accesses and undefined commands, all dropped
    task automatic send_dma_noise();
        logic [1:0] cmd;
        cmd = ($urandom_range(0, 3) == 0) ? CMD_NONE : 2'($urandom_range(0, 1));
        send_item(cmd, 8'($urandom), 8'($urandom));
    endtask

    // Program source, destination and count, start the DMA and return every byte
    task automatic run_dma(input logic [23:0] src, input logic [23:0] dst,
                           input logic [15:0] count, input int noise_pct,
                           input logic readback);
        logic [63:0] setup;
        setup = {count, dst[15:8], dst[7:0], dst[23:16], src[23:16], src[15:8], src[7:0]};
        for (int k = 0; k < 8; k++)
            send_item(iorf_pkg::CMD_WRITE, iorf_pkg::PORT_SRC_LO + 8'(k), setup[k*8 +: 8]);
        send_item(iorf_pkg::CMD_WRITE, iorf_pkg::PORT_DMA_CTL,
                  iorf_pkg::DMA_START_BIT | 8'($urandom_range(0, 127)));
        items_sent += 9;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(1, 100) <= noise_pct)
                send_dma_noise();
            send_item(iorf_pkg::CMD_DATA, 8'($urandom), 8'($urandom));
            items_sent++;
        end
        // Written-back addresses, cleared count and control
        if (readback) begin
            for (int k = 0; k < 9; k++)
                send_item(iorf_pkg::CMD_READ, iorf_pkg::PORT_SRC_LO + 8'(k), 8'($urandom));
            items_sent += 9;
        end
    endtask

    // Random DMA address, sometimes placed just below the 20-bit wrap
    function automatic logic [23:0] dma_address();
        logic [23:0] addr;
        addr = 24'($urandom);
        if ($urandom_range(0, 7) == 0)
            addr = {addr[23:20] | 4'hF, 4'hF, 16'hFFFF - 16'($urandom_range(0, 3))};
        return addr;
    endfunction

    initial begin
        logic [1:0]  cmd;
        logic [7:0]  port;
        logic [7:0]  val;
        logic [15:0] count;
        int          pick;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 16'h0000;
        s_axis_tuser  = iorf_pkg::CMD_READ;
        no_idle       = 1'b0;
        items_sent    = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset value, masked and constant ports
        send_item(iorf_pkg::CMD_READ, 8'h00, 8'h00);
        send_item(iorf_pkg::CMD_READ, 8'hAA, 8'h00);
        send_item(iorf_pkg::CMD_READ, 8'hB3, 8'h00);
        send_item(iorf_pkg::CMD_WRITE, 8'hC0, 8'hFF);
        send_item(iorf_pkg::CMD_READ, 8'hC0, 8'h00);
        send_item(iorf_pkg::CMD_WRITE, 8'hCA, 8'h01);
        send_item(iorf_pkg::CMD_READ, 8'hCA, 8'h00);
        send_item(iorf_pkg::CMD_READ, 8'hBE, 8'hFF);
        send_item(iorf_pkg::CMD_WRITE, 8'hFF, 8'hFF);
        send_item(iorf_pkg::CMD_READ, 8'hFF, 8'h00);
        // Interrupt acknowledge clears bits
        send_item(iorf_pkg::CMD_WRITE, iorf_pkg::PORT_INT_ACK, 8'hFF);
        send_item(iorf_pkg::CMD_READ, iorf_pkg::PORT_INT_ACK, 8'h00);
        // Audio forwards; the write-only audio port reads back from the store
        send_item(iorf_pkg::CMD_READ, iorf_pkg::PORT_AUD_LO, 8'h00);
        send_item(iorf_pkg::CMD_READ, iorf_pkg::PORT_AUD_HI, 8'hFF);
        send_item(iorf_pkg::CMD_WRITE, iorf_pkg::PORT_AUD_HI, 8'hFF);
        send_item(iorf_pkg::CMD_WRITE, iorf_pkg::PORT_AUD_W, 8'h00);
        send_item(iorf_pkg::CMD_READ, iorf_pkg::PORT_AUD_W, 8'h00);
        // Returned data with no DMA, undefined command
        send_item(iorf_pkg::CMD_DATA, 8'h00, 8'hA5);
        send_item(CMD_NONE, 8'hFF, 8'hFF);
        // Control port without the start bit is plain storage
        send_item(iorf_pkg::CMD_WRITE, iorf_pkg::PORT_DMA_CTL, 8'h7F);
        send_item(iorf_pkg::CMD_READ, iorf_pkg::PORT_DMA_CTL, 8'h00);
        items_sent += 21;
        // Zero-count DMA finishes at once; DMA across the 20-bit wrap
        run_dma(24'hF01234, 24'h0ABCDE, 16'd0, 0, 1'b1);
        run_dma(24'hFFFFFE, 24'hFFFFFD, 16'd3, 50, 1'b1);
        drain();

        // Random: DMA runs and plain port accesses in equal share, and some dropped items
        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 15) == 0)
                no_idle = ~no_idle;
            if ($urandom_range(0, 39) == 0)
                drain();
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                count = 16'($urandom_range(0, 8));
                if ($urandom_range(0, 31) == 0)
                    count = 16'h0100 | 16'($urandom_range(0, 255));
                run_dma(dma_address(), dma_address(), count, 20, ($urandom_range(0, 9) < 4));
            end else if (pick < 90) begin
                cmd  = 2'($urandom_range(0, 1));
                port = 8'($urandom);
                val  = 8'($urandom);
                // A start here would run a DMA of arbitrary length
                if (cmd == iorf_pkg::CMD_WRITE && port == iorf_pkg::PORT_DMA_CTL)
                    val = val & ~iorf_pkg::DMA_START_BIT;
                send_item(cmd, port, val);
                items_sent++;
            end else begin
                cmd = ($urandom_range(0, 1) == 0) ? iorf_pkg::CMD_DATA : CMD_NONE;
                send_item(cmd, 8'($urandom), 8'($urandom));
            end
        end

        drain();
        repeat (30) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("[io_register_file_with_dma] OK");
        else
            $display("[io_register_file_with_dma] ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/iorf_pkg.sv
sv/iorf_store.sv
sv/iorf_ctrl.sv
sv/io_register_file_with_dma.sv
dv/iorf_checker.sv
dv/tb.sv
